@@ rtl/ped_pkg.sv @@
// Package for the planar pose-graph edge residual block.
// Holds the fixed-point constants, the arctangent table, the CORDIC gain and the
// item type that moves through the cell chains. Depends on nothing.
package ped_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int CORDIC_STAGES = 18;

    // Pi in Q61, used to derive pi at any fraction width with round to nearest.
    localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
    localparam logic [63:0] PI_F   = (PI_Q61 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
    localparam logic [63:0] PI_30  = (PI_Q61 + (64'd1 << 30)) >> 31;
    localparam logic [63:0] TWO_PI = PI_F << 1;

    // Heading reduction: offset makes the operand positive, then one
    // compare-and-subtract of a shifted 2*pi per cell.
    localparam int          T_W      = $clog2(TWO_PI + 64'd1);
    localparam logic [63:0] SPAN     = 64'd1 << 33;
    localparam int          WRAP_N   = $clog2((SPAN + TWO_PI - 64'd1) / TWO_PI) + 1;
    localparam int          WRAP_W   = T_W + WRAP_N;
    localparam logic [63:0] WRAP_OFF = TWO_PI << (WRAP_N - 1);

    // Weight square root: one root bit per cell.
    localparam int SQ_W = (32 + FRAC_BITS + 1) / 2;

    localparam int PREP_CELLS = (WRAP_N > SQ_W) ? WRAP_N : SQ_W;
    localparam int MAX_CELLS  = (PREP_CELLS > CORDIC_STAGES) ? PREP_CELLS : CORDIC_STAGES;
    localparam int IDX_W      = $clog2(MAX_CELLS + 1);

    // Angle and rotation datapath width, and the residual width before weighting.
    localparam int ZW = 34;
    localparam int RW = 36;

    // Arctangent of 2^-i in Q30, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_q30(input logic [IDX_W-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            IDX_W'(0):  v = ZW'(843314857);
            IDX_W'(1):  v = ZW'(497837829);
            IDX_W'(2):  v = ZW'(263043837);
            IDX_W'(3):  v = ZW'(133525159);
            IDX_W'(4):  v = ZW'(67021687);
            IDX_W'(5):  v = ZW'(33543516);
            IDX_W'(6):  v = ZW'(16775851);
            IDX_W'(7):  v = ZW'(8388437);
            IDX_W'(8):  v = ZW'(4194283);
            IDX_W'(9):  v = ZW'(2097149);
            IDX_W'(10): v = ZW'(1048576);
            default:    v = ZW'(64'd1 << (30 - int'(i)));
        endcase
        return v;
    endfunction

    // Reciprocal of the CORDIC gain in Q30, evaluated at elaboration.
    function automatic logic [63:0] cordic_gain();
        logic [63:0] p;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] rem;
        int i;
        p = 64'd1 << 61;
        for (i = 1; i < CORDIC_STAGES; i++) begin
            p = p + (p >> (2 * i));
        end
        v   = p;
        res = '0;
        b   = 64'd1 << 62;
        while (b > v) begin
            b = b >> 2;
        end
        while (b != 64'd0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        num = (64'd1 << 60) + (res >> 1);
        q   = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= res) begin
                rem  = rem - res;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    localparam logic [63:0] CORDIC_K = cordic_gain();

    // One edge as it moves through the pipeline; each stage uses its own fields.
    typedef struct packed {
        logic signed [31:0]     fx, fy, tx, ty, mx, my;
        logic [WRAP_W-1:0]      wa, wd;
        logic [2*SQ_W-1:0]      ua, ub;
        logic [SQ_W:0]          ra, rb;
        logic [SQ_W-1:0]        qa, qb;
        logic signed [ZW-1:0]   cx, cy, cz, hd;
        logic                   neg;
        logic signed [63:0]     pa, pb, pc, pd;
        logic signed [RW-1:0]   rx, ry;
        logic signed [31:0]     res_x, res_y, res_h;
    } t_item;

endpackage

@@ rtl/ped_if.sv @@
// Channel interfaces of the edge residual block: edge words in, residual words out.
// Each carries valid, ready and the payload. Depends on nothing.
interface ped_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] from_x;
    logic signed [31:0] from_y;
    logic signed [31:0] from_heading;
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
    logic signed [31:0] to_heading;
    logic signed [31:0] meas_dx;
    logic signed [31:0] meas_dy;
    logic signed [31:0] meas_dtheta;
    logic [31:0]        weight_trans;
    logic [31:0]        weight_rot;

    modport source (
        output valid, from_x, from_y, from_heading, to_x, to_y, to_heading,
               meas_dx, meas_dy, meas_dtheta, weight_trans, weight_rot,
        input  ready
    );
    modport sink (
        input  valid, from_x, from_y, from_heading, to_x, to_y, to_heading,
               meas_dx, meas_dy, meas_dtheta, weight_trans, weight_rot,
        output ready
    );
endinterface

interface ped_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_heading;

    modport source (output valid, res_x, res_y, res_heading, input ready);
    modport sink (input valid, res_x, res_y, res_heading, output ready);
endinterface

@@ rtl/ped_prep_cell.sv @@
// One cell of the front chain: a heading reduction step for both angles and
// one root bit for both weight square roots. Depends on ped_pkg.
module ped_prep_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [ped_pkg::IDX_W-1:0] i_idx,
    input  logic                  i_v,
    input  ped_pkg::t_item        i_d,
    output logic                  o_v,
    output ped_pkg::t_item        o_d
);
    import ped_pkg::*;

    logic              r_v;
    t_item             r_d;
    t_item             n_d;
    logic [IDX_W-1:0]  k;
    logic [WRAP_W-1:0] tk;
    logic [SQ_W+2:0]   cat_a, cat_b;
    logic [SQ_W+2:0]   try_a, try_b;

    // Reduction and square-root steps for this cell's position.
    always_comb begin
        n_d   = i_d;
        k     = IDX_W'(WRAP_N - 1) - i_idx;
        tk    = WRAP_W'(TWO_PI) << k;
        cat_a = {i_d.ra, i_d.ua[2*SQ_W-1 -: 2]};
        cat_b = {i_d.rb, i_d.ub[2*SQ_W-1 -: 2]};
        try_a = (SQ_W+3)'({i_d.qa, 2'b01});
        try_b = (SQ_W+3)'({i_d.qb, 2'b01});
        if (i_idx < IDX_W'(WRAP_N)) begin
            if (i_d.wa >= tk) begin
                n_d.wa = i_d.wa - tk;
            end
            if (i_d.wd >= tk) begin
                n_d.wd = i_d.wd - tk;
            end
        end
        if (i_idx < IDX_W'(SQ_W)) begin
            n_d.ua = i_d.ua << 2;
            n_d.ub = i_d.ub << 2;
            if (cat_a >= try_a) begin
                n_d.ra = (SQ_W+1)'(cat_a - try_a);
                n_d.qa = {i_d.qa[SQ_W-2:0], 1'b1};
            end else begin
                n_d.ra = cat_a[SQ_W:0];
                n_d.qa = {i_d.qa[SQ_W-2:0], 1'b0};
            end
            if (cat_b >= try_b) begin
                n_d.rb = (SQ_W+1)'(cat_b - try_b);
                n_d.qb = {i_d.qb[SQ_W-2:0], 1'b1};
            end else begin
                n_d.rb = cat_b[SQ_W:0];
                n_d.qb = {i_d.qb[SQ_W-2:0], 1'b0};
            end
        end
    end

    // Cell register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
            r_d <= n_d;
        end
    end

    assign o_v = r_v;
    assign o_d = r_d;
endmodule

@@ rtl/ped_cordic_cell.sv @@
// One CORDIC rotation cell; the cell position sets the shift and the angle step.
// Depends on ped_pkg.
module ped_cordic_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [ped_pkg::IDX_W-1:0] i_idx,
    input  logic                  i_v,
    input  ped_pkg::t_item        i_d,
    output logic                  o_v,
    output ped_pkg::t_item        o_d
);
    import ped_pkg::*;

    logic                 r_v;
    t_item                r_d;
    t_item                n_d;
    logic signed [ZW-1:0] sx, sy, at;

    // Rotate toward zero residual angle.
    always_comb begin
        n_d = i_d;
        sx  = i_d.cx >>> i_idx;
        sy  = i_d.cy >>> i_idx;
        at  = atan_q30(i_idx);
        if (!i_d.cz[ZW-1]) begin
            n_d.cx = i_d.cx - sy;
            n_d.cy = i_d.cy + sx;
            n_d.cz = i_d.cz - at;
        end else begin
            n_d.cx = i_d.cx + sy;
            n_d.cy = i_d.cy - sx;
            n_d.cz = i_d.cz + at;
        end
    end

    // Cell register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
            r_d <= n_d;
        end
    end

    assign o_v = r_v;
    assign o_d = r_d;
endmodule

@@ rtl/pose_graph_edge_residual.sv @@
// Planar pose-graph edge residual: an accepted edge word passes the input stage, the
// front chain of reduction and root cells, the fold stage, the CORDIC cell chain, the
// rotation, residual, weighting and rounding stages and the output register. Throughput
// is one edge word per cycle, as both chains take one step per cycle, while the skid
// stage is empty; it keeps the input open while one result waits. Synchronous active-low
// reset clears the valid bits only. Depends on ped_pkg, ped_if and the cells.
module pose_graph_edge_residual (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ped_in_if.sink    i_edge,
    ped_out_if.source o_res
);
    import ped_pkg::*;

    typedef struct packed {
        logic signed [31:0] res_x, res_y, res_h;
    } t_res;

    logic  w_en;
    logic  w_take;
    logic  r_s0_v;
    t_item r_s0, n_s0;
    logic  r_f_v;
    t_item r_f, n_f;
    logic  r_m1_v, r_m2_v, r_m3_v, r_m4_v;
    t_item r_m1, r_m2, r_m3, r_m4;
    t_item n_m1, n_m2, n_m3, n_m4;
    logic  r_ov, r_skid_v;
    t_res  r_out, r_sk;

    logic  w_pv [0:PREP_CELLS];
    t_item w_pd [0:PREP_CELLS];
    logic  w_cv [0:CORDIC_STAGES];
    t_item w_cd [0:CORDIC_STAGES];

    logic signed [33:0]   dh;
    logic signed [ZW-1:0] ha, hw, z, c, s;
    logic signed [63:0]   ex, ey;

    // Round half up at the fraction point and clamp to 32 bits.
    function automatic logic signed [31:0] sat_round(input logic signed [63:0] p);
        logic signed [63:0] v;
        v = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    // The whole pipeline moves unless the skid stage holds a word.
    assign w_en         = !r_skid_v;
    assign w_take       = !r_ov || o_res.ready;
    assign i_edge.ready = w_en;

    // Input stage: offset both angles positive and align the weights.
    always_comb begin
        n_s0    = '0;
        dh      = 34'(i_edge.to_heading) - 34'(i_edge.from_heading)
                - 34'(i_edge.meas_dtheta);
        n_s0.fx = i_edge.from_x;
        n_s0.fy = i_edge.from_y;
        n_s0.tx = i_edge.to_x;
        n_s0.ty = i_edge.to_y;
        n_s0.mx = i_edge.meas_dx;
        n_s0.my = i_edge.meas_dy;
        n_s0.wa = WRAP_W'(i_edge.from_heading) + WRAP_W'(WRAP_OFF);
        n_s0.wd = WRAP_W'(dh) + WRAP_W'(WRAP_OFF);
        n_s0.ua = (2*SQ_W)'(i_edge.weight_trans) << FRAC_BITS;
        n_s0.ub = (2*SQ_W)'(i_edge.weight_rot) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_en) begin
            r_s0_v <= i_edge.valid;
            r_s0   <= n_s0;
        end
    end

    // Front chain of reduction and square-root cells.
    assign w_pv[0] = r_s0_v;
    assign w_pd[0] = r_s0;
    for (genvar g = 0; g < PREP_CELLS; g++) begin : g_prep
        ped_prep_cell u_prep (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_idx   (IDX_W'(g)),
            .i_v     (w_pv[g]),
            .i_d     (w_pd[g]),
            .o_v     (w_pv[g+1]),
            .o_d     (w_pd[g+1])
        );
    end

    // Fold stage: finish the wraps, move the source heading to Q30 and into
    // the right half plane, and seed the CORDIC.
    always_comb begin
        n_f = w_pd[PREP_CELLS];
        if (w_pd[PREP_CELLS].wa > WRAP_W'(PI_F)) begin
            ha = $signed(ZW'(w_pd[PREP_CELLS].wa)) - $signed(ZW'(TWO_PI));
        end else begin
            ha = $signed(ZW'(w_pd[PREP_CELLS].wa));
        end
        if (w_pd[PREP_CELLS].wd > WRAP_W'(PI_F)) begin
            hw = $signed(ZW'(w_pd[PREP_CELLS].wd)) - $signed(ZW'(TWO_PI));
        end else begin
            hw = $signed(ZW'(w_pd[PREP_CELLS].wd));
        end
        z     = ha <<< (30 - FRAC_BITS);
        n_f.neg = 1'b0;
        if (z > $signed(ZW'(PI_30 >> 1))) begin
            z       = z - $signed(ZW'(PI_30));
            n_f.neg = 1'b1;
        end else if (z < -$signed(ZW'(PI_30 >> 1))) begin
            z       = z + $signed(ZW'(PI_30));
            n_f.neg = 1'b1;
        end
        n_f.cx = $signed(ZW'(CORDIC_K));
        n_f.cy = '0;
        n_f.cz = z;
        n_f.hd = hw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v <= w_pv[PREP_CELLS];
            r_f   <= n_f;
        end
    end

    // CORDIC cell chain.
    assign w_cv[0] = r_f_v;
    assign w_cd[0] = r_f;
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        ped_cordic_cell u_cordic (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_idx   (IDX_W'(g)),
            .i_v     (w_cv[g]),
            .i_d     (w_cd[g]),
            .o_v     (w_cv[g+1]),
            .o_d     (w_cd[g+1])
        );
    end

    // Rotation products of the measured offset.
    always_comb begin
        n_m1    = w_cd[CORDIC_STAGES];
        c       = w_cd[CORDIC_STAGES].neg ? -w_cd[CORDIC_STAGES].cx : w_cd[CORDIC_STAGES].cx;
        s       = w_cd[CORDIC_STAGES].neg ? -w_cd[CORDIC_STAGES].cy : w_cd[CORDIC_STAGES].cy;
        n_m1.pa = 64'(c) * 64'(w_cd[CORDIC_STAGES].mx);
        n_m1.pb = 64'(s) * 64'(w_cd[CORDIC_STAGES].my);
        n_m1.pc = 64'(s) * 64'(w_cd[CORDIC_STAGES].mx);
        n_m1.pd = 64'(c) * 64'(w_cd[CORDIC_STAGES].my);
    end

    // Rotated offset back to Q.F and the position residuals.
    always_comb begin
        n_m2    = r_m1;
        ex      = (r_m1.pa - r_m1.pb + (64'sd1 <<< 29)) >>> 30;
        ey      = (r_m1.pc + r_m1.pd + (64'sd1 <<< 29)) >>> 30;
        n_m2.rx = RW'(r_m1.tx) - RW'(r_m1.fx) - RW'(ex);
        n_m2.ry = RW'(r_m1.ty) - RW'(r_m1.fy) - RW'(ey);
    end

    // Weighting products.
    always_comb begin
        n_m3    = r_m2;
        n_m3.pa = 64'(r_m2.rx) * 64'($signed({1'b0, r_m2.qa}));
        n_m3.pb = 64'(r_m2.ry) * 64'($signed({1'b0, r_m2.qa}));
        n_m3.pc = 64'(r_m2.hd) * 64'($signed({1'b0, r_m2.qb}));
    end

    // Rounding and saturation.
    always_comb begin
        n_m4       = r_m3;
        n_m4.res_x = sat_round(r_m3.pa);
        n_m4.res_y = sat_round(r_m3.pb);
        n_m4.res_h = sat_round(r_m3.pc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_m3_v <= 1'b0;
            r_m4_v <= 1'b0;
        end else if (w_en) begin
            r_m1_v <= w_cv[CORDIC_STAGES];
            r_m2_v <= r_m1_v;
            r_m3_v <= r_m2_v;
            r_m4_v <= r_m3_v;
            r_m1   <= n_m1;
            r_m2   <= n_m2;
            r_m3   <= n_m3;
            r_m4   <= n_m4;
        end
    end

    // Output register with a one-word skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_take) begin
            if (r_skid_v) begin
                r_ov     <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_ov <= r_m4_v;
            end
        end else if (r_m4_v && w_en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= r_skid_v ? r_sk : t_res'{r_m4.res_x, r_m4.res_y, r_m4.res_h};
        end
        if (!w_take && w_en) begin
            r_sk <= t_res'{r_m4.res_x, r_m4.res_y, r_m4.res_h};
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.res_x       = r_out.res_x;
    assign o_res.res_y       = r_out.res_y;
    assign o_res.res_heading = r_out.res_h;

    // The skid stage only holds a word behind a waiting output word.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_ov)
        else $error("skid word held with no output word");

    // The skid stage fills only when the output was stalled.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_ov && !o_res.ready))
        else $error("skid filled without an output stall");

    // A taken output word with a skid word behind it is replaced by that word.
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && o_res.ready) |=> (!r_skid_v && r_ov))
        else $error("skid word not moved to the output");
endmodule
